/* rtl/sfram_pkg.sv */
// ----------------------------------------------------------------------------
// sfram_pkg
// Opcodes, command codes, frame phases and sizes shared by the SPI FRAM
// device-side logic.
// ----------------------------------------------------------------------------
`default_nettype none

package sfram_pkg;

    localparam int MEM_ADDR_BITS  = 16;
    localparam int ADDR_FULL_BITS = 18;

    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WRSR  = 8'h01;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_SLEEP = 8'hB9;

    localparam logic [7:0] TOP_ADDR_MASK = 8'h03;
    localparam logic [7:0] SR_WRITABLE   = 8'h8C;

    localparam logic [2:0] PHASE_OPCODE = 3'd0;
    localparam logic [2:0] PHASE_ADDR0  = 3'd1;
    localparam logic [2:0] PHASE_ADDR1  = 3'd2;
    localparam logic [2:0] PHASE_ADDR2  = 3'd3;
    localparam logic [2:0] PHASE_DATA   = 3'd4;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_RDSR  = 3'd1,
        CMD_WRSR  = 3'd2,
        CMD_READ  = 3'd3,
        CMD_WRITE = 3'd4
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/spi_fram_slave.sv */
// ----------------------------------------------------------------------------
// spi_fram_slave
// Device side of a serial FRAM: decodes opcode, address and data bytes of
// each frame and serves reads and writes from an on-chip byte memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_mode, i_mosi_byte
//  output  | out       | o_valid / i_stall  | o_miso_byte, o_asleep_now
//
//  One transaction per cycle while the output is not stalled; each result
//  is registered after control update and memory access, then in output reg.
//  The single-port byte memory does one read or one write per transaction.
//  Reset is synchronous; the memory is not cleared and needs no sweep.
//  A stalled output holds; the input stalls only when both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_fram_slave #(
    parameter int MEM_ADDR_BITS = sfram_pkg::MEM_ADDR_BITS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_mode,
    input  wire logic [7:0] i_mosi_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_miso_byte,
    output logic            o_asleep_now
);

    localparam int AW       = MEM_ADDR_BITS;
    localparam int FW       = sfram_pkg::ADDR_FULL_BITS;
    localparam int MEM_SIZE = 2 ** AW;

    logic [7:0] r_mem [MEM_SIZE];

    // control state
    logic             r_wel, n_wel;
    logic             r_sleep, n_sleep;
    logic             r_pend, n_pend;
    logic [2:0]       r_phase, n_phase;
    sfram_pkg::t_cmd  r_cmd, n_cmd;
    logic [FW-1:0]    r_addr, n_addr;
    logic [7:0]       r_status, n_status;

    // memory access of the accepted transaction
    logic             mem_rd, mem_we;
    logic [AW-1:0]    mem_addr;
    logic [AW-1:0]    addr_inc;
    logic [7:0]       miso_now;
    logic [7:0]       status_view;

    // pipeline
    logic             accept, s1_adv;
    logic             r_s1_valid, r_s1_from_mem, r_s1_asleep;
    logic [7:0]       r_s1_miso, r_rdata;
    logic             r_out_valid, r_out_asleep;
    logic [7:0]       r_out_miso;

    assign s1_adv  = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;

    assign mem_addr    = r_addr[AW-1:0];
    assign addr_inc    = mem_addr + 1'b1;
    assign status_view = (r_status & sfram_pkg::SR_WRITABLE) | {6'd0, r_wel, 1'b0};

    always_comb begin
        n_wel    = r_wel;
        n_sleep  = r_sleep;
        n_pend   = r_pend;
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_addr   = r_addr;
        n_status = r_status;
        mem_rd   = 1'b0;
        mem_we   = 1'b0;
        miso_now = 8'd0;
        if (i_mode) begin
            if (r_sleep) begin
                n_sleep = 1'b0;
            end else begin
                if (r_cmd == sfram_pkg::CMD_WRITE || r_cmd == sfram_pkg::CMD_WRSR) begin
                    n_wel = 1'b0;
                end
                if (r_pend) begin
                    n_sleep = 1'b1;
                end
            end
            n_pend  = 1'b0;
            n_phase = sfram_pkg::PHASE_OPCODE;
            n_cmd   = sfram_pkg::CMD_NONE;
        end else if (r_sleep) begin
            n_sleep = 1'b0;
            n_cmd   = sfram_pkg::CMD_NONE;
            n_phase = sfram_pkg::PHASE_DATA;
        end else if (r_phase == sfram_pkg::PHASE_OPCODE) begin
            n_cmd   = sfram_pkg::CMD_NONE;
            n_phase = sfram_pkg::PHASE_ADDR0;
            unique case (i_mosi_byte)
                sfram_pkg::OP_WREN:  n_wel  = 1'b1;
                sfram_pkg::OP_WRDI:  n_wel  = 1'b0;
                sfram_pkg::OP_RDSR:  n_cmd  = sfram_pkg::CMD_RDSR;
                sfram_pkg::OP_WRSR:  n_cmd  = sfram_pkg::CMD_WRSR;
                sfram_pkg::OP_READ:  n_cmd  = sfram_pkg::CMD_READ;
                sfram_pkg::OP_WRITE: n_cmd  = sfram_pkg::CMD_WRITE;
                sfram_pkg::OP_SLEEP: n_pend = 1'b1;
                default: ;
            endcase
        end else begin
            unique case (r_cmd)
                sfram_pkg::CMD_RDSR: begin
                    miso_now = status_view;
                end
                sfram_pkg::CMD_WRSR: begin
                    if (r_phase == sfram_pkg::PHASE_ADDR0 && r_wel) begin
                        n_status = i_mosi_byte & sfram_pkg::SR_WRITABLE;
                    end
                end
                sfram_pkg::CMD_READ, sfram_pkg::CMD_WRITE: begin
                    priority case (r_phase)
                        sfram_pkg::PHASE_ADDR0: begin
                            n_addr = {i_mosi_byte[1:0] & sfram_pkg::TOP_ADDR_MASK[1:0],
                                      16'd0};
                        end
                        sfram_pkg::PHASE_ADDR1: begin
                            n_addr = r_addr | {2'd0, i_mosi_byte, 8'd0};
                        end
                        sfram_pkg::PHASE_ADDR2: begin
                            n_addr = FW'(AW'(r_addr | {10'd0, i_mosi_byte}));
                        end
                        default: begin
                            if (r_cmd == sfram_pkg::CMD_READ) begin
                                mem_rd = 1'b1;
                            end else begin
                                mem_we = r_wel;
                            end
                            n_addr = FW'(addr_inc);
                        end
                    endcase
                end
                default: ;
            endcase
            if (r_phase < sfram_pkg::PHASE_DATA) begin
                n_phase = r_phase + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_mem[mem_addr] <= i_mosi_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && mem_rd) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wel       <= 1'b0;
            r_sleep     <= 1'b0;
            r_pend      <= 1'b0;
            r_phase     <= sfram_pkg::PHASE_OPCODE;
            r_cmd       <= sfram_pkg::CMD_NONE;
            r_addr      <= '0;
            r_status    <= 8'd0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_wel    <= n_wel;
                r_sleep  <= n_sleep;
                r_pend   <= n_pend;
                r_phase  <= n_phase;
                r_cmd    <= n_cmd;
                r_addr   <= n_addr;
                r_status <= n_status;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_from_mem <= mem_rd;
            r_s1_miso     <= miso_now;
            r_s1_asleep   <= n_sleep;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_miso   <= r_s1_from_mem ? r_rdata : r_s1_miso;
            r_out_asleep <= r_s1_asleep;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_miso_byte  = r_out_miso;
    assign o_asleep_now = r_out_asleep;

endmodule

`default_nettype wire

/* rtl/sfram_checker.sv */
// ----------------------------------------------------------------------------
// sfram_checker
// Port-level checks for spi_fram_slave, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sfram_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       i_mode,
    input wire logic [7:0] i_mosi_byte,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_miso_byte,
    input wire logic       o_asleep_now
);

    // nothing in flight right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_mode) && $stable(i_mosi_byte))
        else $error("stalled input changed");

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_miso_byte) && $stable(o_asleep_now))
        else $error("stalled output changed");

    // an empty output register never back-pressures the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // only a frame end can put the device to sleep, and it returns no data
    a_sleep_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_miso_byte != 8'd0 |-> !o_asleep_now)
        else $error("data returned while asleep");

endmodule

bind spi_fram_slave sfram_checker u_sfram_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_mode       (i_mode),
    .i_mosi_byte  (i_mosi_byte),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_miso_byte  (o_miso_byte),
    .o_asleep_now (o_asleep_now)
);

`default_nettype wire

/* verif/spi_fram_slave_chk.sv */
// ----------------------------------------------------------------------------
// spi_fram_slave_chk
// Watches both channels of the SPI FRAM device logic, keeps its own copy of
// the opcode decoder, status register, write latch, sleep logic and byte
// memory, and compares each returned byte and sleep flag with the oldest
// predicted reply.
// ----------------------------------------------------------------------------
module spi_fram_slave_chk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_mode,
    input  logic [7:0] i_mosi_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_miso_byte,
    input  logic       i_asleep_now,
    output int         o_err_cnt,
    output int         o_pending,
    output int         o_result_cnt,
    output int         o_wr_cnt,
    output int         o_rd_cnt,
    output int         o_sleep_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_ADDR_BITS  = sfram_pkg::MEM_ADDR_BITS;
    localparam int ADDR_FULL_BITS = sfram_pkg::ADDR_FULL_BITS;

    localparam logic [7:0] SR_WEL_BIT = 8'h02;

    typedef struct packed {
        logic [7:0] miso;
        logic       asleep;
    } t_reply;

    logic [7:0]                fram_mem [0:(1 << MEM_ADDR_BITS) - 1];
    logic [7:0]                status_reg;
    logic                      wel;
    logic                      asleep;
    logic                      sleep_armed;
    logic [2:0]                phase;
    sfram_pkg::t_cmd           cmd;
    logic [ADDR_FULL_BITS-1:0] addr_reg;

    t_reply reply_q [$];
    t_reply got_reply;
    t_reply want_reply;
    t_reply new_reply;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        o_err_cnt++;
        if (o_err_cnt <= 40)
            $display("%0t mismatch: %s got %h want %h (result %0d)",
                     $realtime, what, got, want, o_result_cnt);
    endtask

    task automatic advance_fram(input logic m, input logic [7:0] b, output t_reply r);
        logic [7:0]               miso;
        logic [MEM_ADDR_BITS-1:0] a;
        miso = 8'h00;
        if (m) begin
            if (asleep) begin
                asleep = 1'b0;
            end else begin
                if (cmd == sfram_pkg::CMD_WRITE || cmd == sfram_pkg::CMD_WRSR)
                    wel = 1'b0;
                if (sleep_armed) begin
                    asleep = 1'b1;
                    o_sleep_cnt++;
                end
            end
            sleep_armed = 1'b0;
            phase       = sfram_pkg::PHASE_OPCODE;
            cmd         = sfram_pkg::CMD_NONE;
        end else if (asleep) begin
            asleep = 1'b0;
            cmd    = sfram_pkg::CMD_NONE;
            phase  = sfram_pkg::PHASE_DATA;
        end else if (phase == sfram_pkg::PHASE_OPCODE) begin
            cmd = sfram_pkg::CMD_NONE;
            case (b)
                sfram_pkg::OP_WREN:  wel = 1'b1;
                sfram_pkg::OP_WRDI:  wel = 1'b0;
                sfram_pkg::OP_RDSR:  cmd = sfram_pkg::CMD_RDSR;
                sfram_pkg::OP_WRSR:  cmd = sfram_pkg::CMD_WRSR;
                sfram_pkg::OP_READ:  cmd = sfram_pkg::CMD_READ;
                sfram_pkg::OP_WRITE: cmd = sfram_pkg::CMD_WRITE;
                sfram_pkg::OP_SLEEP: sleep_armed = 1'b1;
                default:  ;
            endcase
            phase = sfram_pkg::PHASE_ADDR0;
        end else begin
            case (cmd)
                sfram_pkg::CMD_RDSR: begin
                    miso = (status_reg & sfram_pkg::SR_WRITABLE) |
                           (wel ? SR_WEL_BIT : 8'h00);
                end
                sfram_pkg::CMD_WRSR: begin
                    if (phase == sfram_pkg::PHASE_ADDR0 && wel)
                        status_reg = b & sfram_pkg::SR_WRITABLE;
                end
                sfram_pkg::CMD_READ, sfram_pkg::CMD_WRITE: begin
                    if (phase == sfram_pkg::PHASE_ADDR0) begin
                        addr_reg = {b[1:0] & sfram_pkg::TOP_ADDR_MASK[1:0], 16'h0000};
                    end else if (phase == sfram_pkg::PHASE_ADDR1) begin
                        addr_reg[15:8] = b;
                    end else if (phase == sfram_pkg::PHASE_ADDR2) begin
                        addr_reg[7:0] = b;
                        addr_reg = ADDR_FULL_BITS'(addr_reg[MEM_ADDR_BITS-1:0]);
                    end else begin
                        a = addr_reg[MEM_ADDR_BITS-1:0];
                        if (cmd == sfram_pkg::CMD_READ) begin
                            miso = fram_mem[a];
                            o_rd_cnt++;
                        end else if (wel) begin
                            fram_mem[a] = b;
                            o_wr_cnt++;
                        end
                        a = a + 1'b1;
                        addr_reg = ADDR_FULL_BITS'(a);
                    end
                end
                default: ;
            endcase
            if (phase < sfram_pkg::PHASE_DATA)
                phase = phase + 3'd1;
        end
        r.miso   = miso;
        r.asleep = asleep;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            status_reg   = 8'h00;
            wel          = 1'b0;
            asleep       = 1'b0;
            sleep_armed  = 1'b0;
            phase        = sfram_pkg::PHASE_OPCODE;
            cmd          = sfram_pkg::CMD_NONE;
            addr_reg     = '0;
            reply_q.delete();
            o_err_cnt    = 0;
            o_result_cnt = 0;
            o_wr_cnt     = 0;
            o_rd_cnt     = 0;
            o_sleep_cnt  = 0;
        end else begin
            // output side first: a reply never belongs to the transaction taken this edge
            if (i_out_valid && !i_out_stall) begin
                got_reply.miso   = i_miso_byte;
                got_reply.asleep = i_asleep_now;
                if (reply_q.size() == 0) begin
                    report_mismatch("reply with nothing pending", got_reply.miso, 8'h00);
                end else begin
                    want_reply = reply_q.pop_front();
                    if (got_reply.miso !== want_reply.miso)
                        report_mismatch("miso_byte", got_reply.miso, want_reply.miso);
                    if (got_reply.asleep !== want_reply.asleep)
                        report_mismatch("asleep_now", {7'd0, got_reply.asleep},
                                        {7'd0, want_reply.asleep});
                end
                o_result_cnt++;
            end
            if (i_in_valid && !i_in_stall) begin
                advance_fram(i_mode, i_mosi_byte, new_reply);
                reply_q.push_back(new_reply);
            end
        end
        o_pending = reply_q.size();
    end

endmodule

/* verif/spi_fram_slave_tb.sv */
// ----------------------------------------------------------------------------
// spi_fram_slave_tb
// Drives SPI FRAM frames (opcode, address, data and frame-end transactions)
// into the device logic under random source and sink idling, with two long
// sink hold-offs to back the pipeline up. A side checker predicts and compares
// every reply; this module builds the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module spi_fram_slave_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_ADDR_BITS  = sfram_pkg::MEM_ADDR_BITS;
    localparam int ADDR_FULL_BITS = sfram_pkg::ADDR_FULL_BITS;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_mode;
    logic [7:0] i_mosi_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_miso_byte;
    logic       o_asleep_now;

    int err_cnt, pending, result_cnt, wr_cnt, rd_cnt, sleep_cnt;

    int src_idle_pct;
    int rcv_idle_pct;
    int sent_cnt;
    logic hold_off;

    int src_pct [3] = '{29, 69, 0};
    int rcv_pct [3] = '{69, 29, 0};

    // stimulus-side view of the latch, sleep and written cells, so reads only
    // ever touch memory that has been written
    logic                     wel_shadow;
    logic                     asleep_shadow;
    bit                       written [0:(1 << MEM_ADDR_BITS) - 1];
    logic [MEM_ADDR_BITS-1:0] written_list [$];
    logic [7:0]               frame_q [$];

    spi_fram_slave i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_mosi_byte  (i_mosi_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_miso_byte  (o_miso_byte),
        .o_asleep_now (o_asleep_now)
    );

    spi_fram_slave_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_mode       (i_mode),
        .i_mosi_byte  (i_mosi_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_miso_byte  (o_miso_byte),
        .i_asleep_now (o_asleep_now),
        .o_err_cnt    (err_cnt),
        .o_pending    (pending),
        .o_result_cnt (result_cnt),
        .o_wr_cnt     (wr_cnt),
        .o_rd_cnt     (rd_cnt),
        .o_sleep_cnt  (sleep_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d replies pending", pending);
        $display("status: fail");
        $finish;
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= hold_off || ($urandom_range(99) < rcv_idle_pct);
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (sent_cnt >= 150);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
        wait (sent_cnt >= 1000);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    task automatic send_item(input logic m, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= m;
        i_mosi_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        logic [ADDR_FULL_BITS-1:0] full;
        logic [MEM_ADDR_BITS-1:0]  a;
        if (asleep_shadow) begin
            asleep_shadow = 1'b0;
        end else if (frame_q.size() != 0) begin
            case (frame_q[0])
                sfram_pkg::OP_WREN:  wel_shadow = 1'b1;
                sfram_pkg::OP_WRDI:  wel_shadow = 1'b0;
                sfram_pkg::OP_WRSR:  wel_shadow = 1'b0;
                sfram_pkg::OP_SLEEP: asleep_shadow = 1'b1;
                sfram_pkg::OP_WRITE: begin
                    if (wel_shadow && frame_q.size() > 4) begin
                        full = {frame_q[1][1:0], frame_q[2], frame_q[3]};
                        a    = full[MEM_ADDR_BITS-1:0];
                        for (int i = 4; i < frame_q.size(); i++) begin
                            if (!written[a]) begin
                                written[a] = 1'b1;
                                written_list.push_back(a);
                            end
                            a = a + 1'b1;
                        end
                    end
                    wel_shadow = 1'b0;
                end
                default: ;
            endcase
        end
        foreach (frame_q[i])
            send_item(1'b0, frame_q[i]);
        send_item(1'b1, 8'($urandom));
        frame_q.delete();
    endtask

    task automatic send_ops(input int n, input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3,
                            input logic [7:0] b4, input logic [7:0] b5);
        logic [7:0] bs [6];
        bs = '{b0, b1, b2, b3, b4, b5};
        for (int i = 0; i < n; i++)
            frame_q.push_back(bs[i]);
        send_frame();
    endtask

    task automatic push_address(input logic [MEM_ADDR_BITS-1:0] a);
        logic [ADDR_FULL_BITS-1:0] full;
        logic [7:0]                b1;
        full = ADDR_FULL_BITS'($urandom);
        full[MEM_ADDR_BITS-1:0] = a;
        b1 = 8'($urandom);
        b1[1:0] = full[17:16];
        frame_q.push_back(b1);
        frame_q.push_back(full[15:8]);
        frame_q.push_back(full[7:0]);
    endtask

    task automatic build_write();
        logic [MEM_ADDR_BITS-1:0] a;
        int                       n;
        a = MEM_ADDR_BITS'($urandom);
        if ($urandom_range(4) == 0)
            a = '1 - MEM_ADDR_BITS'($urandom_range(7));
        n = $urandom_range(1, 8);
        frame_q.push_back(sfram_pkg::OP_WRITE);
        push_address(a);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    task automatic build_read();
        logic [MEM_ADDR_BITS-1:0] a;
        logic [MEM_ADDR_BITS-1:0] p;
        int                       n;
        int                       k;
        a = written_list[$urandom_range(written_list.size() - 1)];
        n = $urandom_range(1, 8);
        k = 0;
        p = a;
        while (k < n && written[p]) begin
            k++;
            p = p + 1'b1;
        end
        frame_q.push_back(sfram_pkg::OP_READ);
        push_address(a);
        repeat (k) frame_q.push_back(8'($urandom));
    endtask

    task automatic send_random_frame();
        int         roll;
        int         len;
        logic [7:0] op;
        roll = $urandom_range(99);
        if (roll < 18) begin
            frame_q.push_back(sfram_pkg::OP_WREN);
            if ($urandom_range(3) == 0)
                frame_q.push_back(8'($urandom));
        end else if (roll < 22) begin
            frame_q.push_back(sfram_pkg::OP_WRDI);
        end else if (roll < 30) begin
            frame_q.push_back(sfram_pkg::OP_RDSR);
            repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
        end else if (roll < 36) begin
            if ($urandom_range(1) == 0)
                send_ops(1, sfram_pkg::OP_WREN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            frame_q.push_back(sfram_pkg::OP_WRSR);
            repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom));
        end else if (roll < 86) begin
            if (roll >= 62 && written_list.size() != 0) begin
                build_read();
            end else begin
                if ($urandom_range(4) != 0)
                    send_ops(1, sfram_pkg::OP_WREN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                build_write();
            end
        end else if (roll < 89) begin
            frame_q.push_back(sfram_pkg::OP_SLEEP);
            if ($urandom_range(1) == 0)
                frame_q.push_back(8'($urandom));
        end else if (roll < 94) begin
            frame_q.push_back($urandom_range(1) ? sfram_pkg::OP_READ : sfram_pkg::OP_WRITE);
            repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom));
        end else if (roll < 99) begin
            op  = 8'($urandom);
            len = $urandom_range(0, 4);
            if (op == sfram_pkg::OP_READ && len > 3)
                len = 3;
            frame_q.push_back(op);
            repeat (len) frame_q.push_back(8'($urandom));
        end
        send_frame();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_mode        = 1'b0;
        i_mosi_byte   = 8'h00;
        sent_cnt      = 0;
        wel_shadow    = 1'b0;
        asleep_shadow = 1'b0;
        src_idle_pct  = src_pct[0];
        rcv_idle_pct  = rcv_pct[0];
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // status write with masked bits and an ignored second byte
        send_ops(1, sfram_pkg::OP_WREN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_ops(3, sfram_pkg::OP_WRSR, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        // write across the top of memory, masked top address byte
        send_ops(1, sfram_pkg::OP_WREN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_ops(6, sfram_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hA5, 8'h5A);
        send_ops(6, sfram_pkg::OP_READ, 8'hFC, 8'hFF, 8'hFF, 8'h00, 8'hFF);
        // latch cleared by end of write frame
        send_ops(2, sfram_pkg::OP_RDSR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // sleep, wake frame ignored, empty frame, unknown opcode
        send_ops(1, sfram_pkg::OP_SLEEP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_ops(2, sfram_pkg::OP_WREN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_ops(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_ops(2, 8'h77, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);

        for (int ph = 0; ph < 3; ph++) begin
            int target;
            src_idle_pct = src_pct[ph];
            rcv_idle_pct = rcv_pct[ph];
            target = sent_cnt + 400;
            while (sent_cnt < target)
                send_random_frame();
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d transactions in, %0d replies checked", sent_cnt, result_cnt);
        $display("memory writes %0d, memory reads %0d, sleep entries %0d, cells used %0d",
                 wr_cnt, rd_cnt, sleep_cnt, written_list.size());
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/sfram_pkg.sv
rtl/spi_fram_slave.sv
rtl/sfram_checker.sv
verif/spi_fram_slave_chk.sv
verif/spi_fram_slave_tb.sv
